### sv/lr_pkg.sv
// ---------------------------------------------------------------------------
// Line rasterizer package
// Shared types and register map of the line rasterizer.
// ---------------------------------------------------------------------------
package lr_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PADDR_W = 3;

  // Register index is paddr[2]; the low bits are not decoded
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [FIELD_W-1:0] SCREEN_WIDTH_RST  = 16'd320;
  localparam logic [FIELD_W-1:0] SCREEN_HEIGHT_RST = 16'd240;

  typedef enum logic {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic [FIELD_W-1:0] start_x;
    logic [FIELD_W-1:0] start_y;
    logic [FIELD_W-1:0] end_x;
    logic [FIELD_W-1:0] end_y;
    logic [FIELD_W-1:0] line_color;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pixel_x;
    logic [FIELD_W-1:0] pixel_y;
    logic [FIELD_W-1:0] pixel_color;
    logic               visible;
    logic               last_pixel;
    logic               no_line;
  } pixel_t;

endpackage

### sv/line_rasterizer_top.sv
// ---------------------------------------------------------------------------
// Line rasterizer top level
// Bresenham line drawing with screen clipping flags and an APB register port.
// ---------------------------------------------------------------------------
// One pixel per clock while the output is not stalled: every transaction,
// start or next, yields exactly one result transaction. An accepted item is
// stepped by the core while it sits in the input register and lands in the
// output register once the output is free, and a new item is taken every
// cycle while the output is free or being drained. Throughput is set by the
// single add and compare on the registered error term. Registers:
// screen_width at byte address 0, screen_height at byte address 4; write
// only while idle.
module line_rasterizer_top import lr_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [FIELD_W-1:0] start_x_i,
  input  logic [FIELD_W-1:0] start_y_i,
  input  logic [FIELD_W-1:0] end_x_i,
  input  logic [FIELD_W-1:0] end_y_i,
  input  logic [FIELD_W-1:0] line_color_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FIELD_W-1:0] pixel_x_o,
  output logic [FIELD_W-1:0] pixel_y_o,
  output logic [FIELD_W-1:0] pixel_color_o,
  output logic               visible_o,
  output logic               last_pixel_o,
  output logic               no_line_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [FIELD_W-1:0] scr_w_q, scr_h_q;
  logic               cfg_wr;

  item_t  item_q;
  logic   item_valid_q;
  pixel_t pix_q, pix_d;
  logic   out_valid_q;
  logic   out_free, step;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= SCREEN_WIDTH_RST;
      scr_h_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SCREEN_WIDTH)  scr_w_q <= pwdata[FIELD_W-1:0];
      if (paddr[2] == REG_SCREEN_HEIGHT) scr_h_q <= pwdata[FIELD_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_SCREEN_WIDTH) prdata = PDATA_W'(scr_w_q);
    else                              prdata = PDATA_W'(scr_h_q);
  end

  // Two-stage pipeline: input register, then core step into output register
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = item_valid_q && out_free;
  assign in_ready_o = !item_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) item_valid_q <= in_valid_i;
      if (out_free)   out_valid_q  <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.operation  <= op_e'(operation_i);
      item_q.start_x    <= start_x_i;
      item_q.start_y    <= start_y_i;
      item_q.end_x      <= end_x_i;
      item_q.end_y      <= end_y_i;
      item_q.line_color <= line_color_i;
    end
    if (step) pix_q <= pix_d;
  end

  lr_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .item_i          (item_q),
    .screen_width_i  (scr_w_q),
    .screen_height_i (scr_h_q),
    .pixel_o         (pix_d)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_q.pixel_x;
  assign pixel_y_o     = pix_q.pixel_y;
  assign pixel_color_o = pix_q.pixel_color;
  assign visible_o     = pix_q.visible;
  assign last_pixel_o  = pix_q.last_pixel;
  assign no_line_o     = pix_q.no_line;

endmodule

### sv/lr_core.sv
// ---------------------------------------------------------------------------
// Line rasterizer stepping core
// Holds the line state and works out one pixel per step: set-up of a new line
// from its endpoints, one Bresenham step along the major axis, or no_line.
// ---------------------------------------------------------------------------
module lr_core import lr_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  item_t              item_i,
  input  logic [FIELD_W-1:0] screen_width_i,
  input  logic [FIELD_W-1:0] screen_height_i,
  output pixel_t             pixel_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 3;

  logic          active_q, active_d;
  logic [CW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CW-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [EW-1:0] err_q, err_d;
  logic [CW-1:0] maj_q, maj_d, min_q, min_d;
  logic          steep_q, steep_d, down_q, down_d;
  logic [FIELD_W-1:0] color_q, color_d;

  logic [CW-1:0] x0, y0, x1, y1;
  logic [CW-1:0] dx, dy, cy_step;
  logic [EW-1:0] err_inc;
  logic          minor_step, last;
  logic [FIELD_W-1:0] px, py;

  assign x0 = item_i.start_x[CW-1:0];
  assign y0 = item_i.start_y[CW-1:0];
  assign x1 = item_i.end_x[CW-1:0];
  assign y1 = item_i.end_y[CW-1:0];

  always_comb begin
    active_d   = active_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    tgt_x_d    = tgt_x_q;
    tgt_y_d    = tgt_y_q;
    err_d      = err_q;
    maj_d      = maj_q;
    min_d      = min_q;
    steep_d    = steep_q;
    down_d     = down_q;
    color_d    = color_q;
    dx         = '0;
    dy         = '0;
    cy_step    = '0;
    err_inc    = '0;
    minor_step = 1'b0;
    last       = 1'b0;
    unique case (item_i.operation)
      OP_START: begin
        // Reorder so that x never decreases; equal x keeps the first endpoint
        if (x0 > x1) begin
          cur_x_d = x1; cur_y_d = y1; tgt_x_d = x0; tgt_y_d = y0;
        end else begin
          cur_x_d = x0; cur_y_d = y0; tgt_x_d = x1; tgt_y_d = y1;
        end
        color_d = item_i.line_color;
        dx      = tgt_x_d - cur_x_d;
        down_d  = cur_y_d > tgt_y_d;
        dy      = down_d ? (cur_y_d - tgt_y_d) : (tgt_y_d - cur_y_d);
        steep_d = dy > dx;
        maj_d   = steep_d ? dy : dx;
        min_d   = steep_d ? dx : dy;
        err_d   = {2'b00, min_d, 1'b0} - {3'b000, maj_d};
        last    = (maj_d == '0);
        active_d = !last;
      end
      OP_NEXT: begin
        if (active_q) begin
          minor_step = !err_q[EW-1];
          cy_step    = down_q ? (cur_y_q - CW'(1)) : (cur_y_q + CW'(1));
          if (steep_q) begin
            cur_y_d = cy_step;
            if (minor_step) cur_x_d = cur_x_q + CW'(1);
          end else begin
            cur_x_d = cur_x_q + CW'(1);
            if (minor_step) cur_y_d = cy_step;
          end
          err_inc = minor_step ? ({2'b00, min_q, 1'b0} - {2'b00, maj_q, 1'b0})
                               : {2'b00, min_q, 1'b0};
          err_d   = err_q + err_inc;
          last    = steep_q ? (cur_y_d == tgt_y_q) : (cur_x_d == tgt_x_q);
          if (last) active_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign px = FIELD_W'(cur_x_d);
  assign py = FIELD_W'(cur_y_d);

  always_comb begin
    if (item_i.operation == OP_NEXT && !active_q) begin
      pixel_o         = '0;
      pixel_o.no_line = 1'b1;
    end else begin
      pixel_o.pixel_x     = px;
      pixel_o.pixel_y     = py;
      pixel_o.pixel_color = color_d;
      pixel_o.visible     = (px < screen_width_i) && (py < screen_height_i);
      pixel_o.last_pixel  = last;
      pixel_o.no_line     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      err_q    <= '0;
      maj_q    <= '0;
      min_q    <= '0;
      steep_q  <= 1'b0;
      down_q   <= 1'b0;
      color_q  <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      tgt_x_q  <= tgt_x_d;
      tgt_y_q  <= tgt_y_d;
      err_q    <= err_d;
      maj_q    <= maj_d;
      min_q    <= min_d;
      steep_q  <= steep_d;
      down_q   <= down_d;
      color_q  <= color_d;
    end
  end

endmodule
